// ----- hdl/bpcr_pkg.sv -----
// Package for the buffer pool clock replacer.
// Holds command and status codes, fixed field widths and page flag type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpcr_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned PAGE_W   = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ACTIVE_W = 8;

	localparam logic [CMD_W-1:0] CMD_FETCH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 2'd2;

	// Per-page flags kept next to the pin count
	typedef struct packed {
		logic valid;
		logic refd;
		logic dirty;
	} page_flags_t;

endpackage

`default_nettype wire

// ----- hdl/bpcr_ifs.sv -----
// Request and response channel interfaces for the buffer pool clock replacer.
// Depends on bpcr_pkg for fixed field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpcr_req_if #(
	parameter int unsigned FILE_ID_BITS  = 16,
	parameter int unsigned BLOCK_ID_BITS = 32
);
	logic                             valid;
	logic                             ready;
	logic [bpcr_pkg::CMD_W-1:0]       cmd;
	logic [FILE_ID_BITS-1:0]          file_id;
	logic [BLOCK_ID_BITS-1:0]         blk_num;
	logic [bpcr_pkg::PAGE_W-1:0]      page_index;

	modport source (output valid, cmd, file_id, blk_num, page_index, input ready);
	modport sink   (input valid, cmd, file_id, blk_num, page_index, output ready);
endinterface

interface bpcr_rsp_if #(
	parameter int unsigned FILE_ID_BITS  = 16,
	parameter int unsigned BLOCK_ID_BITS = 32
);
	logic                             valid;
	logic                             ready;
	logic [bpcr_pkg::PAGE_W-1:0]      page_out;
	logic                             hit;
	logic                             write_back;
	logic [FILE_ID_BITS-1:0]          victim_file;
	logic [BLOCK_ID_BITS-1:0]         victim_block;
	logic [bpcr_pkg::STATUS_W-1:0]    status;

	modport source (output valid, page_out, hit, write_back, victim_file, victim_block,
		status, input ready);
	modport sink   (input valid, page_out, hit, write_back, victim_file, victim_block,
		status, output ready);
endinterface

`default_nettype wire

// ----- hdl/buffer_pool_clock_replacer_top.sv -----
// Buffer pool page table with clock replacement: control sequencer over bpcr_mem.
// Depends on bpcr_pkg, bpcr_ifs (bpcr_req_if, bpcr_rsp_if) and bpcr_mem.
//
// Usage: one request channel (req) carries cmd, file_id, blk_num and page_index;
// one response channel (rsp) returns one result per request. Both use valid/ready,
// a transfer happens at a rising edge with both high. cfg_we/cfg_wdata write the
// active page count; write it only while no request is in progress.
// Sequence: pin, unpin and mark dirty read the page, then write it (a page outside
// the active range: neither). A fetch scans tags one page per memory read; a miss
// loads a free page, else the clock hand sweeps (up to 2n visits for n active
// pages) to an unpinned page to load, or reports all pinned if none is unpinned.
// The page memory has a single read port; one request is processed at a time and
// req.ready is high only when the sequencer is idle.
// Reset: all pages free, flags and pin counts zero, hand at page 0, active pages
// at the full pool size, capped at 255. Tags are not cleared.
// Stall: the result sits in an output register until taken; the next request is
// accepted meanwhile, and its result waits in the sequencer if rsp is still full.
`timescale 1ns / 1ps
`default_nettype none

module buffer_pool_clock_replacer_top #(
	parameter int unsigned NUM_PAGES     = 128,
	parameter int unsigned FILE_ID_BITS  = 16,
	parameter int unsigned BLOCK_ID_BITS = 32,
	parameter int unsigned PIN_BITS      = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bpcr_pkg::ACTIVE_W-1:0]      cfg_wdata,
	bpcr_req_if.sink                                req,
	bpcr_rsp_if.source                              rsp
);

	localparam int unsigned IDX_W = $clog2(NUM_PAGES);
	localparam int unsigned CW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
	localparam int unsigned ACT_RST = (NUM_PAGES > 255) ? 255 : NUM_PAGES;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_LOAD, S_SW_RD, S_SW_EV, S_PG_RD, S_PG_EV, S_EMIT
	} state_t;

	state_t                          state_q;
	logic [bpcr_pkg::ACTIVE_W-1:0]   active_q;
	logic [bpcr_pkg::CMD_W-1:0]      cmd_q;
	logic [FILE_ID_BITS-1:0]         file_q;
	logic [BLOCK_ID_BITS-1:0]        block_q;
	logic [IDX_W-1:0]                page_q;
	logic [CW-1:0]                   n_q;
	logic [CW-1:0]                   cnt_q;
	logic                            chk_s1;
	logic [IDX_W-1:0]                idx_s1;
	logic                            free_q;
	logic                            unpin_q;
	logic [IDX_W-1:0]                hand_q;
	logic                            wb_q;
	logic [FILE_ID_BITS-1:0]         vf_q;
	logic [BLOCK_ID_BITS-1:0]        vb_q;
	logic                            hit_q;
	logic [bpcr_pkg::STATUS_W-1:0]   st_q;

	logic                            rd_en;
	logic [IDX_W-1:0]                rd_addr;
	bpcr_pkg::page_flags_t           rd_flags_s1;
	logic [PIN_BITS-1:0]             rd_pin_s1;
	logic [FILE_ID_BITS-1:0]         rd_file_s1;
	logic [BLOCK_ID_BITS-1:0]        rd_block_s1;
	logic                            wr_en;
	logic                            wr_tag;
	logic [IDX_W-1:0]                wr_addr;
	bpcr_pkg::page_flags_t           wr_flags;
	logic [PIN_BITS-1:0]             wr_pin;

	logic [CW-1:0]                   act_ext;
	logic [CW-1:0]                   n_now;
	logic [CW-1:0]                   pidx_ext;
	logic [CW-1:0]                   page_ext;
	logic [CW-1:0]                   hand_ext;
	logic [CW-1:0]                   hand_inc;
	logic [IDX_W-1:0]                hand_nxt;
	logic                            match;
	logic                            last;
	logic                            free_now;
	logic                            unpin_now;
	logic                            pin_zero;
	logic                            pin_max;

	// Clamp active page count into 1..NUM_PAGES
	assign act_ext  = CW'(active_q);
	assign n_now    = (act_ext == '0) ? CW'(1) :
		((act_ext > CW'(NUM_PAGES)) ? CW'(NUM_PAGES) : act_ext);
	assign pidx_ext = CW'(req.page_index);
	assign hand_ext = CW'(hand_q);
	assign hand_inc = hand_ext + CW'(1);
	assign hand_nxt = (hand_inc == n_q) ? '0 : hand_inc[IDX_W-1:0];

	// Scan compare on the page read last cycle
	assign match     = rd_flags_s1.valid && (rd_file_s1 == file_q) && (rd_block_s1 == block_q);
	assign last      = (CW'(idx_s1) + CW'(1)) == n_q;
	assign pin_zero  = (rd_pin_s1 == '0);
	assign pin_max   = (rd_pin_s1 == '1);
	assign free_now  = free_q || !rd_flags_s1.valid;
	assign unpin_now = unpin_q || pin_zero;

	// Memory read requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = req.valid && (req.cmd != bpcr_pkg::CMD_FETCH) && (pidx_ext < n_now);
				rd_addr = pidx_ext[IDX_W-1:0];
			end
			S_SCAN: begin
				rd_en   = (cnt_q < n_q);
				rd_addr = cnt_q[IDX_W-1:0];
			end
			S_SW_RD: begin
				rd_en   = 1'b1;
				rd_addr = hand_q;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// Memory write requests
	always_comb begin
		wr_en    = 1'b0;
		wr_tag   = 1'b0;
		wr_addr  = idx_s1;
		wr_flags = rd_flags_s1;
		wr_pin   = rd_pin_s1;
		unique case (state_q)
			S_SCAN: begin
				wr_en         = chk_s1 && match;
				wr_flags.refd = 1'b1;
			end
			S_LOAD: begin
				wr_en    = 1'b1;
				wr_tag   = 1'b1;
				wr_addr  = page_q;
				wr_flags = '{valid: 1'b1, refd: 1'b1, dirty: 1'b0};
				wr_pin   = PIN_BITS'(1);
			end
			S_SW_EV: begin
				wr_en         = rd_flags_s1.refd;
				wr_addr       = hand_q;
				wr_flags.refd = 1'b0;
			end
			S_PG_EV: begin
				wr_en   = 1'b1;
				wr_addr = page_q;
				unique case (cmd_q)
					bpcr_pkg::CMD_PIN:   wr_pin = pin_max ? rd_pin_s1 : rd_pin_s1 + PIN_BITS'(1);
					bpcr_pkg::CMD_UNPIN: wr_pin = pin_zero ? rd_pin_s1 : rd_pin_s1 - PIN_BITS'(1);
					bpcr_pkg::CMD_DIRTY: wr_flags.dirty = 1'b1;
					default:             wr_pin = rd_pin_s1;
				endcase
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	bpcr_mem #(
		.NUM_PAGES     (NUM_PAGES),
		.FILE_ID_BITS  (FILE_ID_BITS),
		.BLOCK_ID_BITS (BLOCK_ID_BITS),
		.PIN_BITS      (PIN_BITS)
	) u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_flags_s1 (rd_flags_s1),
		.rd_pin_s1   (rd_pin_s1),
		.rd_file_s1  (rd_file_s1),
		.rd_block_s1 (rd_block_s1),
		.wr_en       (wr_en),
		.wr_tag      (wr_tag),
		.wr_addr     (wr_addr),
		.wr_flags    (wr_flags),
		.wr_pin      (wr_pin),
		.wr_file     (file_q),
		.wr_block    (block_q)
	);

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.page_out     = page_ext[bpcr_pkg::PAGE_W-1:0] & {bpcr_pkg::PAGE_W{1'b1}};

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= bpcr_pkg::ACTIVE_W'(ACT_RST);
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Sequencer: state, hand and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			hand_q           <= '0;
			chk_s1           <= 1'b0;
			cnt_q            <= '0;
			n_q              <= CW'(1);
			cmd_q            <= bpcr_pkg::CMD_FETCH;
			free_q           <= 1'b0;
			unpin_q          <= 1'b0;
			rsp.valid        <= 1'b0;
		end else begin
			// Drop the result after its transfer unless a new one is loaded
			if (rsp.valid && rsp.ready && (state_q != S_EMIT)) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						file_q  <= req.file_id;
						block_q <= req.blk_num;
						n_q     <= n_now;
						page_q  <= pidx_ext[IDX_W-1:0];
						cnt_q   <= '0;
						chk_s1  <= 1'b0;
						free_q  <= 1'b0;
						unpin_q <= 1'b0;
						wb_q    <= 1'b0;
						vf_q    <= '0;
						vb_q    <= '0;
						hit_q   <= 1'b0;
						st_q    <= bpcr_pkg::ST_OK;
						if (req.cmd == bpcr_pkg::CMD_FETCH) begin
							state_q <= S_SCAN;
						end else if (pidx_ext < n_now) begin
							state_q <= S_PG_RD;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_SCAN: begin
					// Advance the read pointer, check the page read last cycle
					chk_s1 <= (cnt_q < n_q);
					idx_s1 <= cnt_q[IDX_W-1:0];
					if (cnt_q < n_q) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (chk_s1) begin
						if (!free_q && !rd_flags_s1.valid) begin
							page_q <= idx_s1;
						end
						free_q  <= free_now;
						unpin_q <= unpin_now;
						priority if (match) begin
							page_q  <= idx_s1;
							hit_q   <= 1'b1;
							state_q <= S_EMIT;
						end else if (last) begin
							priority if (free_now) begin
								state_q <= S_LOAD;
							end else if (!unpin_now) begin
								page_q  <= '0;
								st_q    <= bpcr_pkg::ST_ALL_PINNED;
								state_q <= S_EMIT;
							end else begin
								if (hand_ext >= n_q) begin
									hand_q <= '0;
								end
								state_q <= S_SW_RD;
							end
						end
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_EV;
				end
				S_SW_EV: begin
					// Clear a set ref bit, take an unpinned page, else move on
					priority if (rd_flags_s1.refd) begin
						hand_q  <= hand_nxt;
						state_q <= S_SW_RD;
					end else if (pin_zero) begin
						page_q <= hand_q;
						wb_q   <= rd_flags_s1.dirty;
						vf_q   <= rd_flags_s1.dirty ? rd_file_s1 : '0;
						vb_q   <= rd_flags_s1.dirty ? rd_block_s1 : '0;
						state_q <= S_LOAD;
					end else begin
						hand_q  <= hand_nxt;
						state_q <= S_SW_RD;
					end
				end
				S_LOAD: begin
					state_q <= S_EMIT;
				end
				S_PG_RD: begin
					state_q <= S_PG_EV;
				end
				S_PG_EV: begin
					if (cmd_q == bpcr_pkg::CMD_UNPIN && pin_zero) begin
						st_q <= bpcr_pkg::ST_UNDERFLOW;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Load the output register once it is free
					if (!rsp.valid || rsp.ready) begin
						rsp.valid        <= 1'b1;
						rsp.hit          <= hit_q;
						rsp.write_back   <= wb_q;
						rsp.victim_file  <= vf_q;
						rsp.victim_block <= vb_q;
						rsp.status       <= st_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Page number travels with the registered result
	logic [IDX_W-1:0] page_out_q;
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!rsp.valid || rsp.ready)) begin
			page_out_q <= page_q;
		end
	end
	assign page_ext = CW'(page_out_q);

	// The sweep only visits active pages
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SW_EV) |-> (hand_ext < n_q))
		else $error("clock hand outside active pages");

	// Reads and writes never hit the same page in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("page memory read and write collide");

	// A write-back goes only with a clean miss
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.write_back) |-> (!rsp.hit && rsp.status == bpcr_pkg::ST_OK))
		else $error("write-back on hit or error result");

	// A load always follows a choice of page and is followed at once by the emit state
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |=> (state_q == S_EMIT))
		else $error("load did not complete");

endmodule

`default_nettype wire

// ----- hdl/bpcr_mem.sv -----
// Page table storage: tag memory and flag/pin memory, one read and one write port.
// Flag/pin entries never written read as zero. Depends on bpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpcr_mem #(
	parameter int unsigned NUM_PAGES     = 128,
	parameter int unsigned FILE_ID_BITS  = 16,
	parameter int unsigned BLOCK_ID_BITS = 32,
	parameter int unsigned PIN_BITS      = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(NUM_PAGES)-1:0]  rd_addr,
	output bpcr_pkg::page_flags_t              rd_flags_s1,
	output logic [PIN_BITS-1:0]                rd_pin_s1,
	output logic [FILE_ID_BITS-1:0]            rd_file_s1,
	output logic [BLOCK_ID_BITS-1:0]           rd_block_s1,
	input  wire logic                          wr_en,
	input  wire logic                          wr_tag,
	input  wire logic [$clog2(NUM_PAGES)-1:0]  wr_addr,
	input  wire bpcr_pkg::page_flags_t         wr_flags,
	input  wire logic [PIN_BITS-1:0]           wr_pin,
	input  wire logic [FILE_ID_BITS-1:0]       wr_file,
	input  wire logic [BLOCK_ID_BITS-1:0]      wr_block
);

	logic [FILE_ID_BITS-1:0]   tag_file_mem  [NUM_PAGES];
	logic [BLOCK_ID_BITS-1:0]  tag_block_mem [NUM_PAGES];
	bpcr_pkg::page_flags_t     flags_mem     [NUM_PAGES];
	logic [PIN_BITS-1:0]       pin_mem       [NUM_PAGES];
	logic [NUM_PAGES-1:0]      written_q;
	logic                      rd_ok_s1;
	bpcr_pkg::page_flags_t     flags_raw_s1;
	logic [PIN_BITS-1:0]       pin_raw_s1;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_s1 <= written_q[rd_addr];
			end
		end
	end

	// Write and read the arrays
	always_ff @(posedge clk) begin
		if (wr_en) begin
			flags_mem[wr_addr] <= wr_flags;
			pin_mem[wr_addr]   <= wr_pin;
		end
		if (wr_en && wr_tag) begin
			tag_file_mem[wr_addr]  <= wr_file;
			tag_block_mem[wr_addr] <= wr_block;
		end
		if (rd_en) begin
			flags_raw_s1 <= flags_mem[rd_addr];
			pin_raw_s1   <= pin_mem[rd_addr];
			rd_file_s1   <= tag_file_mem[rd_addr];
			rd_block_s1  <= tag_block_mem[rd_addr];
		end
	end

	// Unwritten entries read as reset value
	assign rd_flags_s1 = rd_ok_s1 ? flags_raw_s1 : '0;
	assign rd_pin_s1   = rd_ok_s1 ? pin_raw_s1 : '0;

endmodule

`default_nettype wire
